/* rtl/totp_pkg.sv */
package totp_pkg;

  localparam int KEY_WORDS = 6;
  localparam logic [3:0] CFG_KEY_LENGTH = 4'd6;
  localparam logic [3:0] CFG_WINDOW = 4'd7;
  localparam logic [63:0] STEP_SECONDS = 64'd30;
  localparam logic [31:0] CODE_MODULUS = 32'd1000000;
  // floor(2^40 / 1000000); the estimate it gives is low by at most one
  localparam logic [20:0] CODE_RECIP = 21'd1099511;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    begin
      if (rnd < 7'd20) k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
    end
  endfunction

endpackage

/* rtl/totp_sha1_core.sv */
module totp_sha1_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [159:0] h_in,
  input  logic [511:0] blk,
  output logic         done,
  output logic [159:0] h_out
);

  logic [511:0] w;
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   rnd;
  logic         busy;
  logic [31:0]  f, wt, wn, tmp;

  assign wt = w[511:480];
  assign wn = {w[511-13*32 -: 32] ^ w[511-8*32 -: 32] ^ w[511-2*32 -: 32] ^ wt}
              << 1 | ((w[511-13*32 -: 32] ^ w[511-8*32 -: 32] ^ w[511-2*32 -: 32] ^ wt) >> 31);

  always_comb begin
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    tmp = {a[26:0], a[31:27]} + f + e + totp_pkg::sha1_k(rnd) + wt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rnd  <= '0;
      w    <= blk;
      {a, b, c, d, e} <= h_in;
      h_out <= h_in;
    end else if (busy) begin
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
      w <= {w[479:0], wn};
      if (rnd == 7'd79) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        rnd <= rnd + 7'd1;
      end
    end else if (done) begin
      done <= 1'b0;
      h_out <= {h_out[159:128] + a, h_out[127:96] + b, h_out[95:64] + c,
                h_out[63:32] + d, h_out[31:0] + e};
    end
  end

endmodule

/* rtl/totp_code_verifier.sv */
// TOTP verifier: RFC 6238 HMAC-SHA1, six digits, 30 second step. Each item
// takes seconds/30 (mod-15 digit fold, then an exact divide by 15 with
// shift-and-add on one adder), then for each offset from -window to +window
// runs four SHA-1 compressions of 80 rounds each on one shared round unit,
// followed by truncation, a reciprocal modulo-1000000 reduction (estimate,
// back-multiply and subtract, one correcting subtract) and a compare,
// stopping at the first match. A zero key length skips the hashing. The
// block takes no new item until the result has been transferred.
module totp_code_verifier #(
  parameter int MAX_KEY_BYTES = 48,
  parameter int MAX_WINDOW = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] unix_seconds,
  input  logic [19:0] candidate_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        code_matches,
  output logic signed [4:0] matched_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_PREP, S_HASH, S_HWAIT, S_TRUNC, S_MOD, S_CHECK, S_OUT
  } state_t;

  state_t state;
  logic [63:0] key_word [totp_pkg::KEY_WORDS];
  logic [5:0]  key_length;
  logic [3:0]  window;

  logic [63:0] quo, step;
  logic [2:0]  cnt;
  logic [19:0] cand;
  logic [5:0]  off;       // offset index 0..2w
  logic [4:0]  wv;
  logic [1:0]  phase;
  logic [159:0] hreg, ihash;
  logic [511:0] blk;
  logic [31:0] val;
  logic        sha_start, sha_done;
  logic [159:0] sha_out;
  logic [511:0] kpad;
  logic [5:0]  klen;
  logic [4:0]  wclamp;
  logic [7:0]  nib_sum;
  logic [4:0]  fold, fold_lo;
  logic [3:0]  mod15, res15;
  logic [63:0] add_a, add_b, add_sum;
  logic        add_c;
  logic [11:0] qdig;
  logic [31:0] mul_a;
  logic [20:0] mul_b;
  logic [52:0] mul_p;

  assign cfg_ready = 1'b1;
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    klen = (key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length;
    wclamp = (5'(window) > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : 5'(window);
    kpad = '0;
    for (int i = 0; i < 48; i++) begin
      if (6'(i) < klen) kpad[511-8*i -: 8] = key_word[i/8][63-8*(i%8) -: 8];
    end
    // 16 = 1 mod 15, so the nibble sum keeps the residue
    nib_sum = '0;
    for (int i = 0; i < 16; i++) nib_sum = nib_sum + 8'(quo[4*i +: 4]);
    fold = 5'(nib_sum[7:4]) + 5'(nib_sum[3:0]);
    fold_lo = (fold >= 5'd15) ? fold - 5'd15 : fold;
    mod15 = (fold_lo == 5'd15) ? 4'd0 : fold_lo[3:0];
  end

  // shared adder: subtract the residue, multiply by 0x1111..1, negate;
  // the result is the exact quotient by 15 since -0x1111..1 inverts 15 mod 2^64
  always_comb begin
    case (cnt)
      3'd1: begin
        add_a = quo; add_b = ~{60'd0, res15}; add_c = 1'b1;
      end
      3'd2: begin
        add_a = quo; add_b = quo << 4; add_c = 1'b0;
      end
      3'd3: begin
        add_a = quo; add_b = quo << 8; add_c = 1'b0;
      end
      3'd4: begin
        add_a = quo; add_b = quo << 16; add_c = 1'b0;
      end
      3'd5: begin
        add_a = quo; add_b = quo << 32; add_c = 1'b0;
      end
      3'd6: begin
        add_a = '0; add_b = ~quo; add_c = 1'b1;
      end
      default: begin
        add_a = quo; add_b = '0; add_c = 1'b0;
      end
    endcase
    add_sum = add_a + add_b + 64'(add_c);
  end

  // shared multiplier: quotient estimate, then back-multiply by the modulus
  always_comb begin
    case (cnt)
      3'd0: begin
        mul_a = val; mul_b = totp_pkg::CODE_RECIP;
      end
      default: begin
        mul_a = {20'd0, qdig}; mul_b = 21'(totp_pkg::CODE_MODULUS);
      end
    endcase
    mul_p = {21'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    case (phase)
      2'd0: blk = kpad ^ {64{totp_pkg::IPAD}};
      2'd1: blk = {step, 8'h80, 376'd0, 64'd576};
      2'd2: blk = kpad ^ {64{totp_pkg::OPAD}};
      default: blk = {ihash, 8'h80, 280'd0, 64'd672};
    endcase
  end

  totp_sha1_core u_sha (
    .clk(clk), .rst(rst), .start(sha_start),
    .h_in((phase == 2'd0 || phase == 2'd2) ? totp_pkg::SHA1_IV : hreg),
    .blk(blk), .done(sha_done), .h_out(sha_out)
  );

  always_ff @(posedge clk) begin
    sha_start <= !rst && (state == S_HASH || (state == S_PREP && klen != 6'd0));
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < totp_pkg::KEY_WORDS; i++) key_word[i] <= '0;
      key_length <= '0;
      window <= 4'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < totp_pkg::CFG_KEY_LENGTH) key_word[cfg_index[2:0]] <= cfg_data;
        else if (cfg_index == totp_pkg::CFG_KEY_LENGTH) key_length <= cfg_data[5:0];
        else if (cfg_index == totp_pkg::CFG_WINDOW) window <= cfg_data[3:0];
      end
      case (state)
        S_IDLE: if (in_valid) begin
          // seconds/30 = (seconds/2)/15
          quo <= {1'b0, unix_seconds[63:1]}; cnt <= '0;
          cand <= candidate_code; wv <= wclamp;
          code_matches <= 1'b0; matched_offset <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 3'd0) res15 <= mod15;
          else quo <= add_sum;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) state <= S_PREP;
        end
        S_PREP: begin
          if (klen == 6'd0) state <= S_OUT;
          else begin
            step <= quo - 64'(wv); off <= '0; phase <= 2'd0;
            state <= S_HWAIT;
          end
        end
        S_HASH: begin
          state <= S_HWAIT;
        end
        S_HWAIT: if (sha_done) state <= S_TRUNC;
        S_TRUNC: begin
          // sha_out is final in the cycle after done
          hreg <= sha_out;
          if (phase == 2'd1) ihash <= sha_out;
          if (phase == 2'd3) begin
            val <= {1'b0, sha_out[158-8*sha_out[3:0] -: 31]};
            cnt <= '0; state <= S_MOD;
          end else begin
            phase <= phase + 2'd1; state <= S_HASH;
          end
        end
        S_MOD: begin
          case (cnt)
            3'd0: qdig <= mul_p[51:40];
            3'd1: val <= val - mul_p[31:0];
            default: begin
              if (val >= totp_pkg::CODE_MODULUS) val <= val - totp_pkg::CODE_MODULUS;
            end
          endcase
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) state <= S_CHECK;
        end
        S_CHECK: begin
          if (val == 32'(cand)) begin
            code_matches <= 1'b1;
            matched_offset <= 5'(off) - wv;
            state <= S_OUT;
          end else if (off == {wv, 1'b0}) begin
            state <= S_OUT;
          end else begin
            off <= off + 6'd1; step <= step + 64'd1;
            phase <= 2'd0; state <= S_HASH;
          end
        end
        S_OUT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !code_matches) |-> matched_offset == 5'd0)
    else $error("offset set without match");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule
